/* rtl/core/scbn_pkg.sv */
// Shared types, constants and pixel helpers for the scrolling color bar generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package scbn_pkg;

    localparam int BAR_COUNT   = 8;
    localparam int BAR_IDX_W   = 3;
    localparam int DIM_CFG_W   = 13;
    localparam int DVD_W       = 33;   // 2 * frame_number needs 33 bits
    localparam int DIV_CNT_W   = 6;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [31:0] LCG_MUL     = 32'd1664525;
    localparam logic [31:0] LCG_INC     = 32'd1013904223;
    localparam logic [31:0] SEED_MUL    = 32'd2654435761;
    localparam logic [31:0] ALPHA_WORD  = 32'hFF000000;
    localparam logic [7:0]  BAR_LEVEL   = 8'd191;
    localparam int          NOISE_SHIFT = 26;
    localparam int          NOISE_W     = 6;
    localparam logic [9:0]  NOISE_BIAS  = 10'd32;
    localparam logic [9:0]  CHAN_MAX    = 10'd255;

    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_BGRA   = 1'b1;

    localparam logic [12:0] WIDTH_RESET  = 13'd1280;
    localparam logic [12:0] HEIGHT_RESET = 13'd720;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FORMAT = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [DIM_CFG_W-1:0] frame_width;
        logic [DIM_CFG_W-1:0] frame_height;
        logic                 pixel_format;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [31:0] frame_number;
    } cmd_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [BAR_IDX_W-1:0] quot_lsb;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_RUN    = 4'b0001,
        ST_SCROLL = 4'b0010,
        ST_WRAP   = 4'b0100,
        ST_BAR    = 4'b1000
    } back_state_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam rgb_t BAR_RGB [BAR_COUNT] = '{
        '{BAR_LEVEL, BAR_LEVEL, BAR_LEVEL},
        '{BAR_LEVEL, BAR_LEVEL, 8'd0},
        '{8'd0,      BAR_LEVEL, BAR_LEVEL},
        '{8'd0,      BAR_LEVEL, 8'd0},
        '{BAR_LEVEL, 8'd0,      BAR_LEVEL},
        '{BAR_LEVEL, 8'd0,      8'd0},
        '{8'd0,      8'd0,      BAR_LEVEL},
        '{8'd0,      8'd0,      8'd0}
    };

    function automatic logic [7:0] add_clamp(input logic [7:0] base,
                                             input logic [NOISE_W-1:0] noise);
        logic signed [10:0] s;
        s = $signed({3'b000, base}) + $signed({5'b00000, noise})
            - $signed({1'b0, NOISE_BIAS});
        if (s < 0)
            return 8'd0;
        else if (s > $signed({1'b0, CHAN_MAX}))
            return 8'hFF;
        else
            return s[7:0];
    endfunction

    function automatic logic [31:0] pack_pixel(input logic fmt,
                                               input logic [BAR_IDX_W-1:0] bar,
                                               input logic [NOISE_W-1:0] noise);
        rgb_t base;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        base = BAR_RGB[bar];
        r = add_clamp(base.r, noise);
        g = add_clamp(base.g, noise);
        b = add_clamp(base.b, noise);
        if (fmt == FMT_BGRA)
            return ALPHA_WORD | {8'h00, r, g, b};
        else
            return {16'h0000, r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/scbn_front.sv */
// Ingress stage: takes input words and turns them into queue commands.
// Depends on scbn_pkg.
`default_nettype none

module scbn_front
    import scbn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        start_frame,
    input  wire logic [31:0] frame_number,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic load;

    assign in_ready  = !valid_reg || cmd_ready;
    assign load      = in_valid && in_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (valid_reg && cmd_ready)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next            = 1'b1;
            cmd_next.start        = start_frame;
            // frame number only matters on a frame start
            cmd_next.frame_number = start_frame ? frame_number : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

/* rtl/core/scbn_queue.sv */
// Short command FIFO between the front and back parts.
// Depends on scbn_pkg.
`default_nettype none

module scbn_queue
    import scbn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire cmd_t push_cmd,
    output logic      pop_valid,
    input  wire logic pop,
    output cmd_t      head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    cmd_t            entries [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [NW-1:0]   count_reg;
    logic [NW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = count_reg != NW'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;
    assign head       = entries[rd_ptr_reg];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PW'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + NW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

/* rtl/core/scbn_divider.sv */
// Restoring divider, one quotient bit per cycle; dividend comes MSB-aligned.
// Depends on scbn_pkg.
`default_nettype none

module scbn_divider
    import scbn_pkg::*;
#(
    parameter int DW = 13
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire div_req_t       req,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DW-1:0]  divisor,
    output div_rsp_t            rsp,
    output logic [DW-1:0]       remainder
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DVD_W-1:0]     dvd_reg;
    logic [DVD_W-1:0]     dvd_next;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        rem_next;
    logic [DW:0]          trial;
    logic [DW:0]          diff;
    logic                 ge;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = req.count;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in behind the dividend bits
            dvd_next = {dvd_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quot_lsb = dvd_reg[BAR_IDX_W-1:0];
    assign remainder    = rem_reg;

endmodule

`default_nettype wire

/* rtl/core/scbn_back.sv */
// Execution part: raster counters, bar lookup per line, noise generator, output register.
// Depends on scbn_pkg and scbn_divider.
`default_nettype none

module scbn_back
    import scbn_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire logic        cfg_write,
    input  wire logic        q_valid,
    input  wire cmd_t        head,
    output logic             q_pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      pixel_word,
    output logic             end_of_line,
    output logic             end_of_frame
);

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DW = $clog2(MAX_DIMENSION + 1);

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [CW-1:0]        col_reg;
    logic [CW-1:0]        col_next;
    logic [CW-1:0]        row_reg;
    logic [CW-1:0]        row_next;
    logic [31:0]          seed_reg;
    logic [31:0]          seed_next;
    logic [CW-1:0]        scroll_reg;
    logic [CW-1:0]        scroll_next;
    logic [BAR_IDX_W-1:0] bar_reg;
    logic [BAR_IDX_W-1:0] bar_next;
    logic                 bar_valid_reg;
    logic                 bar_valid_next;
    logic                 setup_done_reg;
    logic                 setup_done_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [NOISE_W-1:0]   noise_reg;
    logic [NOISE_W-1:0]   noise_next;
    logic [BAR_IDX_W-1:0] out_bar_reg;
    logic [BAR_IDX_W-1:0] out_bar_next;
    logic                 eol_reg;
    logic                 eol_next;
    logic                 eof_reg;
    logic                 eof_next;

    logic [DW-1:0]        w_eff;
    logic [DW-1:0]        h_eff;
    logic [DW-1:0]        bar_h;
    logic [CW-1:0]        col_use;
    logic [CW-1:0]        row_use;
    logic [DW-1:0]        row_inc;
    logic                 eol;
    logic                 eof;
    logic                 out_free;
    logic [31:0]          lcg_step;
    logic [DW:0]          pos_sum;
    logic [DW:0]          pos;

    div_req_t             div_req;
    div_rsp_t             div_rsp;
    logic [DVD_W-1:0]     div_dividend;
    logic [DW-1:0]        div_divisor;
    logic [DW-1:0]        div_rem;

    always_comb
    begin
        if (cfg.frame_width == '0)
            w_eff = DW'(1);
        else if ({19'd0, cfg.frame_width} > 32'(MAX_DIMENSION))
            w_eff = DW'(MAX_DIMENSION);
        else
            w_eff = DW'(cfg.frame_width);
        if (cfg.frame_height == '0)
            h_eff = DW'(1);
        else if ({19'd0, cfg.frame_height} > 32'(MAX_DIMENSION))
            h_eff = DW'(MAX_DIMENSION);
        else
            h_eff = DW'(cfg.frame_height);
        bar_h = h_eff >> $clog2(BAR_COUNT);
        if (bar_h == '0)
            bar_h = DW'(1);
    end

    // a size change may leave the counters outside the frame
    assign col_use  = (DW'(col_reg) >= w_eff) ? '0 : col_reg;
    assign row_use  = (DW'(row_reg) >= h_eff) ? '0 : row_reg;
    assign row_inc  = DW'(row_use) + DW'(1);
    assign eol      = DW'(col_use) == (w_eff - DW'(1));
    assign eof      = eol && (DW'(row_use) == (h_eff - DW'(1)));
    assign out_free = !out_valid_reg || out_ready;
    assign lcg_step = seed_reg * LCG_MUL + LCG_INC;
    assign pos_sum  = (DW+1)'(div_rem) + (DW+1)'(row_use);
    assign pos      = (pos_sum >= (DW+1)'(h_eff)) ? pos_sum - (DW+1)'(h_eff) : pos_sum;

    assign div_divisor = (state_reg == ST_BAR) ? bar_h : h_eff;

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        seed_next       = seed_reg;
        scroll_next     = scroll_reg;
        bar_next        = bar_reg;
        bar_valid_next  = bar_valid_reg;
        setup_done_next = setup_done_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        noise_next      = noise_reg;
        out_bar_next    = out_bar_reg;
        eol_next        = eol_reg;
        eof_next        = eof_reg;
        q_pop           = 1'b0;
        div_req.start   = 1'b0;
        div_req.count   = DIV_CNT_W'(CW);
        div_dividend    = {scroll_reg, {(DVD_W-CW){1'b0}}};

        unique case (state_reg)
            ST_RUN:
            begin
                if (q_valid)
                begin
                    if (head.start && !setup_done_reg)
                    begin
                        col_next       = '0;
                        row_next       = '0;
                        seed_next      = head.frame_number * SEED_MUL;
                        bar_valid_next = 1'b0;
                        div_req.start  = 1'b1;
                        div_req.count  = DIV_CNT_W'(DVD_W);
                        div_dividend   = {head.frame_number, 1'b0};
                        state_next     = ST_SCROLL;
                    end
                    else if (!bar_valid_reg)
                    begin
                        // scroll mod height first, then row position / bar height
                        div_req.start = 1'b1;
                        state_next    = ST_WRAP;
                    end
                    else if (out_free)
                    begin
                        seed_next       = lcg_step;
                        noise_next      = lcg_step[NOISE_SHIFT +: NOISE_W];
                        out_bar_next    = bar_reg;
                        eol_next        = eol;
                        eof_next        = eof;
                        out_valid_next  = 1'b1;
                        q_pop           = 1'b1;
                        setup_done_next = 1'b0;
                        if (eol)
                        begin
                            col_next       = '0;
                            row_next       = (row_inc >= h_eff) ? '0 : CW'(row_inc);
                            bar_valid_next = 1'b0;
                        end
                        else
                        begin
                            col_next = CW'(DW'(col_use) + DW'(1));
                        end
                    end
                end
            end
            ST_SCROLL:
            begin
                if (div_rsp.done)
                begin
                    scroll_next     = CW'(div_rem);
                    setup_done_next = 1'b1;
                    state_next      = ST_RUN;
                end
            end
            ST_WRAP:
            begin
                if (div_rsp.done)
                begin
                    div_req.start = 1'b1;
                    div_dividend  = {CW'(pos), {(DVD_W-CW){1'b0}}};
                    state_next    = ST_BAR;
                end
            end
            ST_BAR:
            begin
                if (div_rsp.done)
                begin
                    bar_next       = div_rsp.quot_lsb;
                    bar_valid_next = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        if (cfg_write)
            bar_valid_next = 1'b0;
    end

    scbn_divider #(
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .rsp       (div_rsp),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            col_reg        <= '0;
            row_reg        <= '0;
            seed_reg       <= '0;
            scroll_reg     <= '0;
            bar_reg        <= '0;
            bar_valid_reg  <= 1'b0;
            setup_done_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            seed_reg       <= seed_next;
            scroll_reg     <= scroll_next;
            bar_reg        <= bar_next;
            bar_valid_reg  <= bar_valid_next;
            setup_done_reg <= setup_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        noise_reg   <= noise_next;
        out_bar_reg <= out_bar_next;
        eol_reg     <= eol_next;
        eof_reg     <= eof_next;
    end

    assign out_valid    = out_valid_reg;
    assign pixel_word   = pack_pixel(cfg.pixel_format, out_bar_reg, noise_reg);
    assign end_of_line  = eol_reg;
    assign end_of_frame = eof_reg;

endmodule

`default_nettype wire

/* rtl/core/scrolling_color_bar_noise_generator_top.sv */
// Top level of the scrolling color bar generator: config registers and part wiring.
// Depends on scbn_pkg, scbn_front, scbn_queue and scbn_back.
//
//  channel   direction  handshake                payload
//  input     in         in_valid / in_ready      start_frame, frame_number
//  result    out        out_valid / out_ready    pixel_word, end_of_line, end_of_frame
//  config    in         cfg_write                cfg_index, cfg_data
//
// A pixel whose line bar is known goes from the run state straight into the output register.
// The first pixel of a line runs the shared bit-serial divider twice
// (scroll mod height, then position / bar height).
// A frame start adds a run of 33 divider steps for (2*frame) mod height.
// Reset clears all counters, the seed and the queue; no clearing pass.
// A stalled output holds one word while the queue and the front register take three more.
`default_nettype none

module scrolling_color_bar_noise_generator_top
    import scbn_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        start_frame,
    input  wire logic [31:0] frame_number,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      pixel_word,
    output logic             end_of_line,
    output logic             end_of_frame
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic q_valid;
    logic q_pop;
    cmd_t q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  cfg_next.frame_width  = cfg_data;
                REG_HEIGHT: cfg_next.frame_height = cfg_data;
                REG_FORMAT: cfg_next.pixel_format = cfg_data[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= WIDTH_RESET;
            cfg_reg.frame_height <= HEIGHT_RESET;
            cfg_reg.pixel_format <= FMT_RGB565;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scbn_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_frame  (start_frame),
        .frame_number (frame_number),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    scbn_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_cmd   (cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    scbn_back #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cfg_write    (cfg_write),
        .q_valid      (q_valid),
        .head         (q_head),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_word   (pixel_word),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    a_eof_has_eol: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!end_of_frame || end_of_line))
        else $error("end of frame without end of line");

    a_bgra_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg_reg.pixel_format == FMT_BGRA) |-> (pixel_word[31:24] == 8'hFF))
        else $error("BGRA word without opaque alpha");

    a_rgb565_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg_reg.pixel_format == FMT_RGB565) |-> (pixel_word[31:16] == 16'h0000))
        else $error("RGB565 word with upper bits set");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for scrolling_color_bar_noise_generator_top: pixel stream vs. predictor.
// Depends on scbn_pkg (register codes, format codes, constants) and the RTL top level.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scbn_pkg::*;

    localparam int MAX_DIM      = 4096;
    localparam int HOLDOFF_CYC  = 300;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 160;
    localparam int FRAME_CAP    = 160;

    typedef struct packed {
        logic [31:0] word;
        logic        eol;
        logic        eof;
    } pixel_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_write    = 1'b0;
    logic [1:0]  cfg_index    = REG_WIDTH;
    logic [12:0] cfg_data     = '0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic        start_frame  = 1'b0;
    logic [31:0] frame_number = '0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic [31:0] pixel_word;
    logic        end_of_line;
    logic        end_of_frame;

    // predictor copy of the block's registers and raster state
    logic [12:0] gen_width  = WIDTH_RESET;
    logic [12:0] gen_height = HEIGHT_RESET;
    logic        gen_format = FMT_RGB565;
    logic [11:0] gen_col    = '0;
    logic [11:0] gen_row    = '0;
    logic [11:0] gen_scroll = '0;
    logic [31:0] gen_seed   = '0;
    logic [2:0]  gen_bar    = '0;

    cmd_t   pending_words[$];
    pixel_t expected_pixels[$];

    logic in_fire       = 1'b0;
    int   issued_count  = 0;
    int   checked_count = 0;
    int   errors        = 0;
    int   starts_sent   = 0;
    int   eof_seen      = 0;
    int   cfg_settings  = 0;
    int   send_idle_pct = 10;
    int   recv_idle_pct = 74;
    int   stall_asks    = 0;
    int   stall_seen    = 0;
    int   stall_left    = 0;
    int   cur_w         = 1280;
    int   cur_h         = 720;

    scrolling_color_bar_noise_generator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_frame  (start_frame),
        .frame_number (frame_number),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_word   (pixel_word),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #6ms;
        $display("%0t: timeout with %0d of %0d words checked", $realtime, checked_count,
                 issued_count);
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [12:0] fit_dim(input logic [12:0] v);
        if (v == 13'd0)
            return 13'd1;
        if (v > MAX_DIM)
            return 13'(MAX_DIM);
        return v;
    endfunction

    function automatic logic [7:0] noisy_level(input logic lit, input int d);
        int s;
        s = (lit ? int'(BAR_LEVEL) : 0) + d;
        if (s < 0)
            return 8'd0;
        if (s > int'(CHAN_MAX))
            return 8'hFF;
        return 8'(s);
    endfunction

    // Advance the raster by one pixel and return what the block should emit.
    function automatic pixel_t next_pixel(input logic start, input logic [31:0] fnum);
        logic [12:0] w;
        logic [12:0] h;
        logic [12:0] bar_h;
        logic [12:0] pos;
        logic [32:0] twice;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        int          d;
        pixel_t      px;
        w = fit_dim(gen_width);
        h = fit_dim(gen_height);
        if (start)
        begin
            gen_col    = '0;
            gen_row    = '0;
            twice      = {fnum, 1'b0};
            gen_scroll = 12'(twice % h);
            gen_seed   = fnum * SEED_MUL;
        end
        if ({1'b0, gen_col} >= w)
            gen_col = '0;
        if ({1'b0, gen_row} >= h)
            gen_row = '0;
        bar_h = 13'(h / BAR_COUNT);
        if (bar_h == 13'd0)
            bar_h = 13'd1;
        pos     = ({1'b0, gen_row} + ({1'b0, gen_scroll} % h)) % h;
        gen_bar = 3'((pos / bar_h) % BAR_COUNT);

        gen_seed = gen_seed * LCG_MUL + LCG_INC;
        d = int'({26'd0, gen_seed[31:26]}) - int'(NOISE_BIAS);

        // bar order white..black: red lit when bit 1 clear, green bit 2, blue bit 0
        r = noisy_level(!gen_bar[1], d);
        g = noisy_level(!gen_bar[2], d);
        b = noisy_level(!gen_bar[0], d);
        if (gen_format == FMT_BGRA)
            px.word = ALPHA_WORD | {8'h00, r, g, b};
        else
            px.word = {16'h0000, r[7:3], g[7:2], b[7:3]};

        px.eol = ({1'b0, gen_col} == w - 13'd1);
        px.eof = px.eol && ({1'b0, gen_row} == h - 13'd1);
        if (px.eol)
        begin
            gen_col = '0;
            gen_row = ({1'b0, gen_row} + 13'd1 >= h) ? 12'd0 : gen_row + 12'd1;
        end
        else
        begin
            gen_col = gen_col + 12'd1;
        end
        return px;
    endfunction

    // Predictor updates and result checking, all on the rising edge.
    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:  gen_width  = cfg_data;
                    REG_HEIGHT: gen_height = cfg_data;
                    REG_FORMAT: gen_format = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_pixels.push_back(next_pixel(start_frame, frame_number));
            if (out_valid && out_ready)
            begin
                checked_count++;
                got.word = pixel_word;
                got.eol  = end_of_line;
                got.eof  = end_of_frame;
                if (got.eof)
                    eof_seen++;
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t: expected no word, got %h eol %b eof %b", $realtime,
                             got.word, got.eol, got.eof);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got.word !== want.word || got.eol !== want.eol
                        || got.eof !== want.eof)
                    begin
                        errors++;
                        $display("%0t: word %0d expected %h eol %b eof %b, got %h eol %b eof %b",
                                 $realtime, checked_count, want.word, want.eol, want.eof,
                                 got.word, got.eol, got.eof);
                    end
                end
            end
        end
    end

    // Sender: holds a word until taken, otherwise pulls the next one or idles.
    always @(negedge clk)
    begin
        cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_fire)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = pending_words.pop_front();
                in_valid     <= 1'b1;
                start_frame  <= c.start;
                frame_number <= c.frame_number;
            end
            else
            begin
                in_valid     <= 1'b0;
                start_frame  <= 1'($urandom);
                frame_number <= $urandom;
            end
        end
    end

    // Receiver: random stalls plus an occasional long hold-off.
    always @(negedge clk)
    begin
        if (stall_seen != stall_asks)
        begin
            stall_seen = stall_asks;
            stall_left = HOLDOFF_CYC;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_item(input logic start, input logic [31:0] fnum);
        cmd_t c;
        c.start        = start;
        c.frame_number = fnum;
        pending_words.push_back(c);
        issued_count++;
        if (start)
            starts_sent++;
    endtask

    // A frame start followed by a whole frame of pixels (at most FRAME_CAP), or a cut-off part of one.
    task automatic queue_frame(input logic cut_short);
        int          area;
        int          n;
        int          k;
        logic [31:0] fnum;
        area = cur_w * cur_h;
        if (area > FRAME_CAP)
            area = FRAME_CAP;
        n = cut_short ? $urandom_range(area - 1, 0) : area;
        k = $urandom_range(9);
        fnum = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
        queue_item(1'b1, fnum);
        repeat (n) queue_item(1'b0, $urandom);
    endtask

    task automatic wait_drained;
        while (checked_count < issued_count)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_regs(input logic [12:0] w, input logic [12:0] h,
                              input logic [12:0] fmt_data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= REG_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= REG_FORMAT;
        cfg_data  <= fmt_data;
        @(negedge clk);
        cfg_write <= 1'b0;
        cur_w = int'(fit_dim(w));
        cur_h = int'(fit_dim(h));
        cfg_settings++;
    endtask

    initial
    begin
        int          seg;
        int          k;
        int          phase_base;
        logic [12:0] w;
        logic [12:0] h;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: pixels on the reset seed, then starts at both ends of the range
        queue_item(1'b0, 32'hFFFF_FFFF);
        queue_item(1'b1, 32'h0);
        queue_item(1'b0, $urandom);
        queue_item(1'b1, 32'hFFFF_FFFF);
        queue_item(1'b0, $urandom);
        wait_drained;

        // zero sizes act as 1x1, BGRA format
        write_regs(13'd0, 13'd0, 13'h1FFF);
        queue_item(1'b1, 32'h8000_0000);
        repeat (2) queue_item(1'b0, $urandom);
        wait_drained;

        // oversize values clamp to the maximum
        write_regs(13'h1FFF, 13'h1FFF, 13'h1FFE);
        queue_item(1'b1, 32'hFFFF_FFFF);
        queue_item(1'b0, $urandom);
        wait_drained;

        // run into row 1, column 3, then shrink: column, row and scroll all out of range
        write_regs(13'd10, 13'd4, 13'h0001);
        queue_item(1'b1, 32'd3);
        repeat (13) queue_item(1'b0, $urandom);
        wait_drained;
        write_regs(13'd3, 13'd1, 13'h0000);
        repeat (4) queue_item(1'b0, $urandom);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            seg = ph / 4;
            wait_drained;
            send_idle_pct = (seg == 0) ? 10 : (seg == 1) ? 74 : 0;
            recv_idle_pct = (seg == 0) ? 74 : (seg == 1) ? 10 : 0;
            k = $urandom_range(9);
            if (ph == PHASES - 2)
            begin
                w = 13'h1FFF;
                h = 13'd0;
            end
            else if (ph == PHASES - 1)
            begin
                w = 13'd1;
                h = 13'(MAX_DIM);
            end
            else if (k < 6)
            begin
                w = 13'($urandom_range(12, 0));
                h = 13'($urandom_range(12, 0));
            end
            else if (k < 8)
            begin
                w = 13'($urandom_range(64, 1));
                h = 13'($urandom_range(MAX_DIM, 1));
            end
            else
            begin
                w = 13'($urandom);
                h = 13'($urandom);
            end
            write_regs(w, h, {12'($urandom), 1'($urandom)});

            phase_base = issued_count;
            while (issued_count - phase_base < PHASE_ITEMS)
            begin
                k = $urandom_range(99);
                if (k < 70)
                    queue_frame(1'b0);
                else if (k < 85)
                    queue_frame(1'b1);
                else
                    queue_item(1'($urandom), $urandom);
            end
            // long output hold-off while the sender keeps offering words
            if (ph == 1 || ph == 9)
                stall_asks++;
        end

        wait_drained;
        repeat (100) @(negedge clk);
        if (expected_pixels.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected words never arrived", $realtime,
                     expected_pixels.size());
        end
        $display("Checked %0d pixel words over %0d register settings (both formats, sizes 1..max).",
                 checked_count, cfg_settings);
        $display("Frame starts sent: %0d, end-of-frame words seen: %0d, errors: %0d.",
                 starts_sent, eof_seen, errors);
        if (errors == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
